FILE: sv/rpe_pkg.sv
// shared types, constants and saturating helpers for the rls parameter estimator
// no dependencies; imported by every module of the block
package rpe_pkg;

	localparam int NUM_PARAMS = 4;
	localparam int IDX_W      = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
	localparam int CNT_W      = $clog2(NUM_PARAMS + 1);
	localparam int DATA_W     = 32;
	localparam int P_W        = 48;
	localparam int ACC_W      = 64;
	localparam int LAM_W      = 17;
	localparam int TDATA_W    = (NUM_PARAMS + 1) * DATA_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [LAM_W-1:0] LAM_MIN = 17'd52429;
	localparam logic [LAM_W-1:0] LAM_MAX = 17'd65536;

	localparam logic [P_W-1:0] COV_MIN    = 48'd268;
	localparam logic [P_W-1:0] COV_MAX    = 48'd268435456000000;
	localparam logic [P_W-1:0] COV_RST    = 48'd268435456000;
	localparam logic [P_W-1:0] P_HI       = 48'h7FFF_FFFF_FFFF;
	localparam logic [P_W-1:0] DIAG_FLOOR = 48'd268;

	localparam logic [ACC_W-1:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ICOV   = 2'd1;

	// lane operations, issued one at a time to all lanes
	typedef enum logic [3:0] {
		LOP_RST,
		LOP_V,
		LOP_Q,
		LOP_S,
		LOP_E,
		LOP_K,
		LOP_TH,
		LOP_PM,
		LOP_PD
	} lop_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LANE_GO,
		ST_LANE_WAIT,
		ST_MERGE_GO,
		ST_MERGE_WAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             valid;
		lop_t             op;
		logic [IDX_W-1:0] idx;
	} lane_cmd_t;

	typedef struct packed {
		logic start;
		logic sub;
	} mrg_cmd_t;

	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] t;
		t = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (t[ACC_W] != t[ACC_W-1]) begin
			sat_add = t[ACC_W] ? ~MAG_MAX : MAG_MAX;
		end else begin
			sat_add = t[ACC_W-1:0];
		end
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] t;
		t = {a[ACC_W-1], a} - {b[ACC_W-1], b};
		if (t[ACC_W] != t[ACC_W-1]) begin
			sat_sub = t[ACC_W] ? ~MAG_MAX : MAG_MAX;
		end else begin
			sat_sub = t[ACC_W-1:0];
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
			clamp32 = v[DATA_W-1:0];
		end else begin
			clamp32 = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [P_W-1:0] clamp48(input logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:P_W-1] == '0 || v[ACC_W-1:P_W-1] == '1) begin
			clamp48 = v[P_W-1:0];
		end else begin
			clamp48 = v[ACC_W-1] ? ~P_HI : P_HI;
		end
	endfunction

endpackage

FILE: sv/rpe_mul.sv
// sequential signed multiplier, 64 x 64 via four 32 x 32 partial products
// result shifted right by 16 or 32, truncated toward zero and saturated; uses rpe_pkg
module rpe_mul import rpe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] a,
	input  logic signed [ACC_W-1:0] b,
	input  logic                    sh32,
	output logic                    done,
	output logic signed [ACC_W-1:0] res
);

	logic [ACC_W-1:0]   ma_q, mb_q;
	logic               neg_q, sh32_q, busy_q, done_q;
	logic [2:0]         cnt_q;
	logic [ACC_W-1:0]   pp_s1;
	logic [2*ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] res_q;

	logic [31:0]        opa, opb;
	logic [ACC_W-1:0]   prod;
	logic [1:0]         k;
	logic [2*ACC_W-1:0] pp_ext, shifted;
	logic [ACC_W-1:0]   mag;

	always_comb begin
		// cnt 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
		opa     = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		opb     = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		prod    = opa * opb;
		k       = 2'(cnt_q - 3'd1);
		case (k) inside
			2'd0:       pp_ext = {64'd0, pp_s1};
			2'd1, 2'd2: pp_ext = {32'd0, pp_s1, 32'd0};
			default:    pp_ext = {pp_s1, 64'd0};
		endcase
		shifted = sh32_q ? (acc_q >> 32) : (acc_q >> 16);
		mag     = (|shifted[2*ACC_W-1:ACC_W-1]) ? MAG_MAX : shifted[ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q   <= a[ACC_W-1] ? ACC_W'(-a) : a;
			mb_q   <= b[ACC_W-1] ? ACC_W'(-b) : b;
			neg_q  <= a[ACC_W-1] ^ b[ACC_W-1];
			sh32_q <= sh32;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) pp_s1 <= prod;
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4) acc_q <= acc_q + pp_ext;
			if (cnt_q == 3'd5) res_q <= neg_q ? ACC_W'(-mag) : mag;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: sv/rpe_div.sv
// restoring divider, one quotient bit per cycle: (|num| << 16 or 32) / |den|
// quotient truncated toward zero and saturated to 63 bits; uses rpe_pkg
module rpe_div import rpe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] num,
	input  logic signed [ACC_W-1:0] den,
	input  logic                    sh32,
	output logic                    done,
	output logic signed [ACC_W-1:0] res
);

	logic [ACC_W-1:0] r_q, lo_q, d_q, qt_q;
	logic             neg_q, sat_q, busy_q, done_q;
	logic [6:0]       cnt_q;
	logic signed [ACC_W-1:0] res_q;

	logic [ACC_W-1:0] mn, md, hi0, lo0;
	logic [ACC_W:0]   rr, rd;
	logic             qbit;
	logic [ACC_W-1:0] mag;

	always_comb begin
		mn   = num[ACC_W-1] ? ACC_W'(-num) : num;
		md   = den[ACC_W-1] ? ACC_W'(-den) : den;
		hi0  = sh32 ? (mn >> 32) : (mn >> 48);
		lo0  = sh32 ? (mn << 32) : (mn << 16);
		rr   = {r_q, lo_q[ACC_W-1]};
		rd   = rr - {1'b0, d_q};
		qbit = (rr >= {1'b0, d_q});
		mag  = (sat_q || qt_q[ACC_W-1]) ? MAG_MAX : qt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				// fixed length even on overflow so all lanes finish together
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 7'd64) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= hi0;
			lo_q  <= lo0;
			d_q   <= md;
			qt_q  <= '0;
			neg_q <= num[ACC_W-1] ^ den[ACC_W-1];
			sat_q <= (hi0 >= md);
		end else if (busy_q) begin
			if (cnt_q == 7'd64) begin
				res_q <= neg_q ? ACC_W'(-mag) : mag;
			end else begin
				r_q  <= qbit ? rd[ACC_W-1:0] : rr[ACC_W-1:0];
				lo_q <= {lo_q[ACC_W-2:0], 1'b0};
				qt_q <= {qt_q[ACC_W-2:0], qbit};
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: sv/rpe_lane.sv
// one estimator lane: owns a covariance row and one estimate element
// runs the lane operations with its own multiplier and divider; uses rpe_pkg, rpe_mul, rpe_div
module rpe_lane import rpe_pkg::*; (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [IDX_W-1:0]                     lane_id,
	input  lane_cmd_t                            cmd,
	input  logic [NUM_PARAMS-1:0][DATA_W-1:0]    phi,
	input  logic [NUM_PARAMS-1:0][P_W-1:0]       col,
	input  logic [NUM_PARAMS-1:0][ACC_W-1:0]     qv,
	input  logic signed [ACC_W-1:0]              s,
	input  logic signed [DATA_W-1:0]             e,
	input  logic                                 zeroed,
	input  logic [LAM_W-1:0]                     lam,
	input  logic [P_W-1:0]                       diag,
	output logic                                 done,
	output logic [NUM_PARAMS-1:0][P_W-1:0]       row,
	output logic signed [DATA_W-1:0]             theta,
	output logic signed [ACC_W-1:0]              q,
	output logic signed [ACC_W-1:0]              term
);

	logic [NUM_PARAMS-1:0][P_W-1:0] row_q;
	logic signed [DATA_W-1:0]       theta_q;
	logic signed [ACC_W-1:0]        v_q, q_q, k_q, t_q, term_q;
	lop_t                           op_q;
	logic [IDX_W-1:0]               idx_q;
	logic                           done_q;

	logic                    mul_start, mul_sh32, mul_done;
	logic signed [ACC_W-1:0] mul_a, mul_b, mul_res;
	logic                    div_start, div_sh32, div_done;
	logic signed [ACC_W-1:0] div_num, div_den, div_res;
	logic signed [P_W-1:0]   p_new;
	logic [DATA_W-1:0]       phi_own;

	assign phi_own = phi[lane_id];

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		mul_sh32  = 1'b0;
		mul_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_sh32  = 1'b0;
		div_start = 1'b0;
		unique case (cmd.op)
			LOP_V: begin
				mul_a     = {{(ACC_W-P_W){row_q[cmd.idx][P_W-1]}}, row_q[cmd.idx]};
				mul_b     = {{(ACC_W-DATA_W){phi[cmd.idx][DATA_W-1]}}, phi[cmd.idx]};
				mul_start = cmd.valid;
			end
			LOP_Q: begin
				mul_a     = {{(ACC_W-P_W){col[cmd.idx][P_W-1]}}, col[cmd.idx]};
				mul_b     = {{(ACC_W-DATA_W){phi[cmd.idx][DATA_W-1]}}, phi[cmd.idx]};
				mul_start = cmd.valid;
			end
			LOP_S: begin
				mul_a     = {{(ACC_W-DATA_W){phi_own[DATA_W-1]}}, phi_own};
				mul_b     = v_q;
				mul_start = cmd.valid;
			end
			LOP_E: begin
				mul_a     = {{(ACC_W-DATA_W){phi_own[DATA_W-1]}}, phi_own};
				mul_b     = {{(ACC_W-DATA_W){theta_q[DATA_W-1]}}, theta_q};
				mul_start = cmd.valid;
			end
			LOP_TH: begin
				mul_a     = k_q;
				mul_b     = {{(ACC_W-DATA_W){e[DATA_W-1]}}, e};
				mul_sh32  = 1'b1;
				mul_start = cmd.valid;
			end
			LOP_PM: begin
				mul_a     = k_q;
				mul_b     = qv[cmd.idx];
				mul_sh32  = 1'b1;
				mul_start = cmd.valid;
			end
			LOP_K: begin
				div_num   = v_q;
				div_den   = s;
				div_sh32  = 1'b1;
				div_start = cmd.valid && !zeroed;
			end
			LOP_PD: begin
				div_num   = t_q;
				div_den   = {{(ACC_W-LAM_W){1'b0}}, lam};
				div_start = cmd.valid;
			end
			default: ;
		endcase
	end

	rpe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sh32   (mul_sh32),
		.done   (mul_done),
		.res    (mul_res)
	);

	rpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.sh32   (div_sh32),
		.done   (div_done),
		.res    (div_res)
	);

	// new covariance entry, diagonal floored
	always_comb begin
		p_new = clamp48(div_res);
		if (idx_q == lane_id && p_new < $signed(DIAG_FLOOR)) p_new = DIAG_FLOOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			op_q    <= LOP_RST;
			idx_q   <= '0;
			theta_q <= '0;
			for (int j = 0; j < NUM_PARAMS; j++) begin
				row_q[j] <= (IDX_W'(j) == lane_id) ? COV_RST : '0;
			end
		end else begin
			done_q <= mul_done || div_done;
			if (cmd.valid) begin
				op_q  <= cmd.op;
				idx_q <= cmd.idx;
				if (cmd.op == LOP_RST) begin
					done_q  <= 1'b1;
					theta_q <= '0;
					for (int j = 0; j < NUM_PARAMS; j++) begin
						row_q[j] <= (IDX_W'(j) == lane_id) ? diag : '0;
					end
				end
				if (cmd.op == LOP_K && zeroed) done_q <= 1'b1;
			end
			if (mul_done && op_q == LOP_TH) begin
				theta_q <= clamp32(sat_add({{(ACC_W-DATA_W){theta_q[DATA_W-1]}}, theta_q},
					mul_res));
			end
			if (div_done && op_q == LOP_PD) row_q[idx_q] <= p_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.op == LOP_K && zeroed) k_q <= '0;
		if (mul_done) begin
			case (op_q) inside
				LOP_V:        v_q    <= sat_add((idx_q == '0) ? '0 : v_q, mul_res);
				LOP_Q:        q_q    <= sat_add((idx_q == '0) ? '0 : q_q, mul_res);
				LOP_S, LOP_E: term_q <= mul_res;
				LOP_PM: begin
					t_q <= sat_sub({{(ACC_W-P_W){row_q[idx_q][P_W-1]}}, row_q[idx_q]}, mul_res);
				end
				default: ;
			endcase
		end
		if (div_done && op_q == LOP_K) k_q <= div_res;
	end

	assign done  = done_q;
	assign row   = row_q;
	assign theta = theta_q;
	assign q     = q_q;
	assign term  = term_q;

endmodule

FILE: sv/rpe_merge.sv
// merging stage: folds the per-lane terms in lane order with saturation
// gives S = lambda + sum, or the innovation y - sum clamped to 32 bits; uses rpe_pkg
module rpe_merge import rpe_pkg::*; (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mrg_cmd_t                         cmd,
	input  logic [NUM_PARAMS-1:0][ACC_W-1:0] terms,
	input  logic [LAM_W-1:0]                 lam,
	input  logic signed [DATA_W-1:0]         target,
	output logic                             done,
	output logic signed [ACC_W-1:0]          res
);

	logic                    busy_q, done_q, sub_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [ACC_W-1:0] acc_q, res_q;
	logic signed [ACC_W-1:0] term_sel;
	logic signed [DATA_W-1:0] e_sat;

	assign term_sel = terms[cnt_q[IDX_W-1:0]];
	assign e_sat    = clamp32(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NUM_PARAMS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sub_q <= cmd.sub;
			acc_q <= cmd.sub ? {{(ACC_W-DATA_W){target[DATA_W-1]}}, target}
				: {{(ACC_W-LAM_W-12){1'b0}}, lam, 12'd0};
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(NUM_PARAMS)) begin
				res_q <= sub_q ? {{(ACC_W-DATA_W){e_sat[DATA_W-1]}}, e_sat} : acc_q;
			end else begin
				acc_q <= sub_q ? sat_sub(acc_q, term_sel) : sat_add(acc_q, term_sel);
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: sv/rls_parameter_estimator_core.sv
// Recursive least squares estimator with forgetting factor.
// Input beats (s_*): tuser = op (1 restart, 0 update); tdata = phi_0..phi_3, target, Q16.16.
// Each beat yields exactly one output beat (m_*): tdata = theta_0..theta_3, innovation;
// tuser = gain_zeroed. Config writes (cfg_wen, cfg_addr, cfg_wdata) are registered:
// address 0 forgetting factor (clamped 0.8..1.0), address 1 initial covariance
// (clamped 1e-6..1e6, used at the next restart); other addresses are ignored.
// One item is processed at a time by four lanes, each with its own 64-bit multiplier
// (4 partial products) and a restoring divider giving one quotient bit per cycle.
// An update's time is dominated by the gain and covariance divisions; when the gain is
// zeroed the gain step skips its division. The next beat can be taken the cycle after
// the result is loaded. s_tready is high only while no item is in flight. The result
// sits in an output register; a stalled receiver holds it there while the next item is
// already taken, and that item finishes only once the register is free. Reset loads
// lambda = 1.0, covariance 1000 on the diagonal and zero estimates.
module rls_parameter_estimator_core import rpe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,   // phi_0, phi_1, phi_2, phi_3, target
	input  logic                  s_tuser,   // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // theta_0, theta_1, theta_2, theta_3, innovation
	output logic                  m_tuser,   // gain_zeroed
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [P_W-1:0]        cfg_wdata
);

	state_t state_q, state_d;
	lop_t   ph_q, ph_nx;
	logic [IDX_W-1:0] idx_q, idx_nx;
	logic   last_idx;

	logic [LAM_W-1:0] lam_q;
	logic [P_W-1:0]   icov_q, diag;

	logic [NUM_PARAMS-1:0][DATA_W-1:0] phi_q;
	logic signed [DATA_W-1:0]          target_q, e_q;
	logic signed [ACC_W-1:0]           s_q;
	logic                              zeroed_q;

	logic [NUM_PARAMS-1:0][NUM_PARAMS-1:0][P_W-1:0] rows, cols;
	logic [NUM_PARAMS-1:0][ACC_W-1:0]  qs, terms;
	logic [NUM_PARAMS-1:0][DATA_W-1:0] thetas;
	logic [NUM_PARAMS-1:0]             lane_done;
	logic                              lanes_done;

	lane_cmd_t lane_cmd;
	mrg_cmd_t  mrg_cmd;
	logic                    mrg_done;
	logic signed [ACC_W-1:0] mrg_res;

	logic m_tvalid_q, m_tuser_q, out_free, out_load, in_beat;
	logic [TDATA_W-1:0] m_tdata_q;

	assign in_beat    = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign lanes_done = &lane_done;
	assign diag       = (icov_q > P_HI) ? P_HI : icov_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q  <= LAM_MAX;
			icov_q <= COV_RST;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				CFG_LAMBDA: begin
					if (cfg_wdata[LAM_W-1:0] < LAM_MIN) lam_q <= LAM_MIN;
					else if (cfg_wdata[LAM_W-1:0] > LAM_MAX) lam_q <= LAM_MAX;
					else lam_q <= cfg_wdata[LAM_W-1:0];
				end
				CFG_ICOV: begin
					if (cfg_wdata < COV_MIN) icov_q <= COV_MIN;
					else if (cfg_wdata > COV_MAX) icov_q <= COV_MAX;
					else icov_q <= cfg_wdata;
				end
				default: ;
			endcase
		end
	end

	// lanes, with the covariance column of lane i wired from element i of every row
	for (genvar i = 0; i < NUM_PARAMS; i++) begin : g_lane
		for (genvar j = 0; j < NUM_PARAMS; j++) begin : g_col
			assign cols[i][j] = rows[j][i];
		end
		rpe_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.lane_id (IDX_W'(i)),
			.cmd     (lane_cmd),
			.phi     (phi_q),
			.col     (cols[i]),
			.qv      (qs),
			.s       (s_q),
			.e       (e_q),
			.zeroed  (zeroed_q),
			.lam     (lam_q),
			.diag    (diag),
			.done    (lane_done[i]),
			.row     (rows[i]),
			.theta   (thetas[i]),
			.q       (qs[i]),
			.term    (terms[i])
		);
	end

	rpe_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mrg_cmd),
		.terms  (terms),
		.lam    (lam_q),
		.target (target_q),
		.done   (mrg_done),
		.res    (mrg_res)
	);

	// operation sequence
	always_comb begin
		ph_nx    = ph_q;
		idx_nx   = idx_q;
		last_idx = (idx_q == IDX_W'(NUM_PARAMS - 1));
		unique case (ph_q)
			LOP_V: begin
				if (last_idx) begin
					ph_nx  = LOP_Q;
					idx_nx = '0;
				end else begin
					idx_nx = IDX_W'(idx_q + 1'b1);
				end
			end
			LOP_Q: begin
				if (last_idx) begin
					ph_nx  = LOP_S;
					idx_nx = '0;
				end else begin
					idx_nx = IDX_W'(idx_q + 1'b1);
				end
			end
			LOP_S:  ph_nx = LOP_K;
			LOP_K:  ph_nx = LOP_E;
			LOP_E:  ph_nx = LOP_TH;
			LOP_TH: begin
				ph_nx  = LOP_PM;
				idx_nx = '0;
			end
			LOP_PM: ph_nx = LOP_PD;
			LOP_PD: begin
				ph_nx  = LOP_PM;
				idx_nx = IDX_W'(idx_q + 1'b1);
			end
			default: ph_nx = LOP_RST;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_beat) state_d = ST_LANE_GO;
			ST_LANE_GO:   state_d = ST_LANE_WAIT;
			ST_LANE_WAIT: begin
				if (lanes_done) begin
					if (ph_q == LOP_S || ph_q == LOP_E) state_d = ST_MERGE_GO;
					else if (ph_q == LOP_RST || (ph_q == LOP_PD && last_idx)) state_d = ST_FIN;
					else state_d = ST_LANE_GO;
				end
			end
			ST_MERGE_GO:   state_d = ST_MERGE_WAIT;
			ST_MERGE_WAIT: if (mrg_done) state_d = ST_LANE_GO;
			ST_FIN:        if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		lane_cmd.valid = (state_q == ST_LANE_GO);
		lane_cmd.op    = ph_q;
		lane_cmd.idx   = idx_q;
		mrg_cmd.start  = (state_q == ST_MERGE_GO);
		mrg_cmd.sub    = (ph_q == LOP_E);
		out_load       = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ph_q       <= LOP_RST;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_beat) begin
				ph_q  <= s_tuser ? LOP_RST : LOP_V;
				idx_q <= '0;
			end else if ((state_q == ST_LANE_WAIT && lanes_done && ph_q != LOP_S &&
				ph_q != LOP_E) || (state_q == ST_MERGE_WAIT && mrg_done)) begin
				ph_q  <= ph_nx;
				idx_q <= idx_nx;
			end
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			phi_q    <= s_tdata[NUM_PARAMS*DATA_W-1:0];
			target_q <= s_tdata[TDATA_W-1:NUM_PARAMS*DATA_W];
			e_q      <= '0;
			zeroed_q <= 1'b0;
		end
		if (state_q == ST_MERGE_WAIT && mrg_done) begin
			if (ph_q == LOP_S) begin
				s_q      <= mrg_res;
				zeroed_q <= mrg_res[ACC_W-1] || (mrg_res == '0);
			end else begin
				e_q <= mrg_res[DATA_W-1:0];
			end
		end
		if (out_load) begin
			m_tdata_q <= {e_q, thetas};
			m_tuser_q <= zeroed_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// lanes run the same operation and must finish on the same cycle
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_done) |-> lanes_done)
		else $error("lanes finished out of step");

	a_lane_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_done) |-> (state_q == ST_LANE_WAIT))
		else $error("lane completion outside lane wait");

	a_merge_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mrg_done |-> (state_q == ST_MERGE_WAIT))
		else $error("merge completion outside merge wait");

	a_beat_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_LANE_GO && idx_q == '0))
		else $error("accepted beat did not start the lanes");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && m_tvalid_q) |-> m_tready)
		else $error("output register overwritten while held");

endmodule

FILE: tb/sv/rls_parameter_estimator_core_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the rls parameter estimator core
// depends on rpe_pkg and rls_parameter_estimator_core; drives random update and restart beats
module rls_parameter_estimator_core_test;
	import rpe_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam logic OP_UPDATE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;
	localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
	localparam int STALL_LIMIT = 20000;
	localparam int RAND_PER_PHASE = 360;

	typedef struct packed {
		logic                   op;
		logic [3:0][DATA_W-1:0] phi;
		logic [DATA_W-1:0]      target;
	} sample_t;

	typedef struct packed {
		logic [3:0][DATA_W-1:0] theta;
		logic [DATA_W-1:0]      innov;
		logic                   zeroed;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [P_W-1:0] cfg_wdata = '0;

	rls_parameter_estimator_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	sample_t   pending_samples[$];
	estimate_t expected_estimates[$];
	int errors = 0;
	int results_seen = 0;
	int samples_left = 0;
	bit stim_done = 1'b0;

	// predictor state
	longint lambda_q16;
	longint icov_q28;
	longint cov_q28[4][4];
	longint theta_q16[4];

	function automatic logic [63:0] magnitude(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint signed_sat(logic [127:0] m, bit neg);
		logic [63:0] r;
		r = (m > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m[63:0];
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint mul_trunc(longint a, longint b, int sh);
		logic [127:0] p;
		p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		return signed_sat(p >> sh, (a < 0) != (b < 0));
	endfunction

	function automatic longint div_trunc(longint num, longint den, int sh);
		logic [127:0] n;
		n = {64'd0, magnitude(num)} << sh;
		return signed_sat(n / {64'd0, magnitude(den)}, (num < 0) != (den < 0));
	endfunction

	function automatic longint add_sat(longint a, longint b);
		logic signed [64:0] t;
		t = {a[63], a} + {b[63], b};
		if (t[64] != t[63]) return t[64] ? S64_MIN : S64_MAX;
		return longint'(t[63:0]);
	endfunction

	function automatic longint sub_sat(longint a, longint b);
		logic signed [64:0] t;
		t = {a[63], a} - {b[63], b};
		if (t[64] != t[63]) return t[64] ? S64_MIN : S64_MAX;
		return longint'(t[63:0]);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic reload_estimator();
		longint d;
		d = (icov_q28 > longint'(P_HI)) ? longint'(P_HI) : icov_q28;
		for (int i = 0; i < 4; i++) begin
			theta_q16[i] = 0;
			for (int j = 0; j < 4; j++) cov_q28[i][j] = (i == j) ? d : 0;
		end
	endtask

	task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [P_W-1:0] val);
		longint v;
		if (idx == CFG_LAMBDA) begin
			v = longint'(val[LAM_W-1:0]);
			lambda_q16 = clip(v, longint'(LAM_MIN), longint'(LAM_MAX));
		end else if (idx == CFG_ICOV) begin
			v = longint'(val);
			icov_q28 = clip(v, longint'(COV_MIN), longint'(COV_MAX));
		end
	endtask

	task automatic predict_update(sample_t smp);
		longint phi[4], v[4], q[4], k[4];
		longint s, e, t;
		bit zg;
		estimate_t r;
		zg = 1'b0;
		if (smp.op == OP_RESTART) begin
			reload_estimator();
			e = 0;
		end else begin
			for (int i = 0; i < 4; i++) phi[i] = longint'($signed(smp.phi[i]));
			s = lambda_q16 <<< 12;
			e = longint'($signed(smp.target));
			for (int i = 0; i < 4; i++) begin
				v[i] = 0;
				q[i] = 0;
				for (int j = 0; j < 4; j++) begin
					v[i] = add_sat(v[i], mul_trunc(cov_q28[i][j], phi[j], 16));
					q[i] = add_sat(q[i], mul_trunc(phi[j], cov_q28[j][i], 16));
				end
			end
			for (int i = 0; i < 4; i++) s = add_sat(s, mul_trunc(phi[i], v[i], 16));
			zg = (s <= 0);
			for (int i = 0; i < 4; i++) k[i] = zg ? 0 : div_trunc(v[i], s, 32);
			for (int i = 0; i < 4; i++) e = sub_sat(e, mul_trunc(phi[i], theta_q16[i], 16));
			e = clip(e, -64'sd2147483648, 64'sd2147483647);
			for (int i = 0; i < 4; i++)
				theta_q16[i] = clip(add_sat(theta_q16[i], mul_trunc(k[i], e, 32)),
					-64'sd2147483648, 64'sd2147483647);
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					t = sub_sat(cov_q28[i][j], mul_trunc(k[i], q[j], 32));
					cov_q28[i][j] = clip(div_trunc(t, lambda_q16, 16),
						-longint'(P_HI) - 1, longint'(P_HI));
				end
			end
			for (int i = 0; i < 4; i++)
				if (cov_q28[i][i] < longint'(DIAG_FLOOR)) cov_q28[i][i] = longint'(DIAG_FLOOR);
		end
		for (int i = 0; i < 4; i++) r.theta[i] = theta_q16[i][31:0];
		r.innov = e[31:0];
		r.zeroed = zg;
		expected_estimates.push_back(r);
	endtask

	// mostly small well-conditioned values, with the odd full-range one
	function automatic logic [31:0] rand_q16();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
		if (sel < 9) return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
		return $urandom;
	endfunction

	function automatic sample_t make_sample(logic op, logic [31:0] p0, logic [31:0] p1,
		logic [31:0] p2, logic [31:0] p3, logic [31:0] y);
		sample_t smp;
		smp.op = op;
		smp.phi[0] = p0;
		smp.phi[1] = p1;
		smp.phi[2] = p2;
		smp.phi[3] = p3;
		smp.target = y;
		return smp;
	endfunction

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [P_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		apply_register(idx, val);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic drain_block();
		wait (pending_samples.size() == 0 && !s_tvalid && expected_estimates.size() == 0);
		repeat (700) @(posedge clk);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		sample_t smp;
		lambda_q16 = longint'(LAM_MAX);
		icov_q28 = longint'(COV_RST);
		reload_estimator();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes of every field, restart, all-zero regressor
		pending_samples.push_back(make_sample(OP_UPDATE, 0, 0, 0, 0, 0));
		pending_samples.push_back(make_sample(OP_UPDATE, 32'h0001_0000, 0, 0, 0, 32'h0002_0000));
		pending_samples.push_back(make_sample(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pending_samples.push_back(make_sample(OP_UPDATE, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		pending_samples.push_back(make_sample(OP_RESTART, '1, '1, '1, '1, '1));
		pending_samples.push_back(make_sample(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0001,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		pending_samples.push_back(make_sample(OP_UPDATE, 0, 0, 0, 0, 32'h7FFF_FFFF));
		pending_samples.push_back(make_sample(OP_RESTART, 0, 0, 0, 0, 0));
		for (int i = 0; i < 12; i++)
			pending_samples.push_back(make_sample(OP_UPDATE, rand_q16(), rand_q16(), rand_q16(),
				rand_q16(), rand_q16()));

		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				drain_block();
				case (phase)
					1: begin
						write_register(CFG_LAMBDA, '0);
						write_register(CFG_ICOV, '0);
					end
					2: begin
						write_register(CFG_LAMBDA, '1);
						write_register(CFG_ICOV, '1);
					end
					3: begin
						write_register(CFG_LAMBDA, P_W'($urandom_range(52429, 65536)));
						write_register(CFG_ICOV, 48'd2684354560);
						write_register(CFG_SPARE_A, '1);
						write_register(CFG_SPARE_B, '0);
					end
					default: begin
						write_register(CFG_LAMBDA, P_W'(LAM_MIN));
						write_register(CFG_ICOV, COV_RST);
					end
				endcase
				pending_samples.push_back(make_sample(OP_RESTART, $urandom, $urandom, $urandom,
					$urandom, $urandom));
			end
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				smp = make_sample($urandom_range(0, 39) == 0 ? OP_RESTART : OP_UPDATE,
					rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
				pending_samples.push_back(smp);
			end
			samples_left = pending_samples.size();
		end
		drain_block();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// sender
	int send_gap = 0;
	always @(posedge clk) begin
		sample_t cur;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				// tdata carries the regressor low and the target high
				predict_update(sample_t'({s_tuser, s_tdata[4*DATA_W-1:0],
					s_tdata[5*DATA_W-1:4*DATA_W]}));
				if (samples_left > 0) samples_left--;
			end
			if (s_tvalid && !s_tready) begin
				// hold the beat until taken
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				if (samples_left > 150 && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(1, 17);
					s_tvalid <= 1'b0;
				end else begin
					cur = pending_samples.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur.op;
					s_tdata <= {cur.target, cur.phi[3], cur.phi[2], cur.phi[1], cur.phi[0]};
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver and comparison
	int recv_hold = 0;
	always @(posedge clk) begin
		estimate_t exp_r, got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.theta = m_tdata[4*DATA_W-1:0];
				got.innov = m_tdata[5*DATA_W-1:4*DATA_W];
				got.zeroed = m_tuser;
				if (expected_estimates.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, actual %h", $time, got);
				end else begin
					exp_r = expected_estimates.pop_front();
					for (int i = 0; i < 4; i++)
						if (got.theta[i] !== exp_r.theta[i]) begin
							errors++;
							$display("%0t: theta_%0d expected %h actual %h", $time, i,
								exp_r.theta[i], got.theta[i]);
						end
					if (got.innov !== exp_r.innov) begin
						errors++;
						$display("%0t: innovation expected %h actual %h", $time,
							exp_r.innov, got.innov);
					end
					if (got.zeroed !== exp_r.zeroed) begin
						errors++;
						$display("%0t: gain_zeroed expected %b actual %b", $time,
							exp_r.zeroed, got.zeroed);
					end
				end
				// one long back-pressure stretch so the block fills and blocks its input
				if (results_seen == 40) recv_hold = 3000;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_tready <= 1'b0;
			end else if (samples_left > 150 && $urandom_range(0, 11) == 0) begin
				recv_hold = $urandom_range(1, 17);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no beat on either side
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule

FILE: rls_parameter_estimator_core.f
sv/rpe_pkg.sv
sv/rpe_mul.sv
sv/rpe_div.sv
sv/rpe_lane.sv
sv/rpe_merge.sv
sv/rls_parameter_estimator_core.sv
tb/sv/rls_parameter_estimator_core_test.sv
